### sv/ccf_pkg.sv
// Shared constants, register codes and pipeline sideband type for the
// charge force field clamp. No dependencies.
package ccf_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;

   localparam int GAIN_W  = 32;
   localparam int RAD_W   = 31;
   localparam int MAX_W   = 31;
   localparam int FORCE_W = 32;
   localparam int QUO_W   = 32;   // quotient bits kept; larger ones saturate
   localparam int MASK_W  = 3;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_FIELD_GAIN    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SPHERE_RADIUS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_FORCE     = 2'd2;

   localparam int RSP_DATA_W = ((3 * FORCE_W + MASK_W + 7) / 8) * 8;

   typedef struct packed {
      logic [2:0] neg;    // result sign per lane
      logic [2:0] ovf;    // quotient too wide, saturate
      logic       dz;     // zero denominator
      logic       near;   // near zone branch
   } ccf_side_type;

endpackage

### sv/ccf_div_pipe.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Depends on ccf_pkg for the sideband type.
module ccf_div_pipe #(
   parameter int DEN_W = 66,
   parameter int QW    = ccf_pkg::QUO_W
) (
   input  logic                      clock,
   input  logic [QW-1:0]             en,
   input  logic [DEN_W-1:0]          den,
   input  logic [2:0][DEN_W-1:0]     rem0,
   input  logic [2:0][QW-1:0]        nlo,
   input  ccf_pkg::ccf_side_type     side,
   output logic [2:0][QW-1:0]        quo,
   output ccf_pkg::ccf_side_type     side_out
);

   logic [2:0][DEN_W-1:0] rem_ff  [QW];
   logic [2:0][QW-1:0]    nl_ff   [QW];
   logic [DEN_W-1:0]      den_ff  [QW];
   ccf_pkg::ccf_side_type side_ff [QW];

   genvar s, l;
   generate
      for (s = 0; s < QW; s++) begin : g_stage
         logic [2:0][DEN_W-1:0] rem_prev;
         logic [2:0][QW-1:0]    nl_prev;
         logic [DEN_W-1:0]      den_prev;
         ccf_pkg::ccf_side_type side_prev;
         logic [2:0][DEN_W-1:0] rem_in;
         logic [2:0][QW-1:0]    nl_in;

         if (s == 0) begin : g_first
            assign rem_prev  = rem0;
            assign nl_prev   = nlo;
            assign den_prev  = den;
            assign side_prev = side;
         end else begin : g_next
            assign rem_prev  = rem_ff[s-1];
            assign nl_prev   = nl_ff[s-1];
            assign den_prev  = den_ff[s-1];
            assign side_prev = side_ff[s-1];
         end

         for (l = 0; l < 3; l++) begin : g_lane
            logic [DEN_W:0] trial;
            logic           ge;
            assign trial = {rem_prev[l], nl_prev[l][QW-1]};
            assign ge    = trial >= {1'b0, den_prev};
            assign rem_in[l] = ge ? DEN_W'(trial - {1'b0, den_prev}) : DEN_W'(trial);
            assign nl_in[l]  = {nl_prev[l][QW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en[s]) begin
               rem_ff[s]  <= rem_in;
               nl_ff[s]   <= nl_in;
               den_ff[s]  <= den_prev;
               side_ff[s] <= side_prev;
            end
         end
      end
   endgenerate

   assign quo      = nl_ff[QW-1];
   assign side_out = side_ff[QW-1];

endmodule

### sv/charge_force_field_clamp.sv
// Charge force field with per-component clamp, top level.
// Depends on ccf_pkg and ccf_div_pipe.
//
//  channel | dir | beat contents (low bits first)
//  req_    | in  | tdata: first_x, first_y, first_z, second_x, second_y, second_z
//  rsp_    | out | tdata: force_x, force_y, force_z, clamp_mask; tuser: near_zone
//  csr_    | in  | write: 0 field_gain, 1 sphere_radius, 2 max_force
//
// An accepted req beat reaches its rsp beat through six front stages
// (difference, magnitude, products, sum, branch select, overflow check),
// one stage per quotient bit in the divider and one output stage. One beat
// per cycle is sustained while rsp is ready. Each stage loads when it is
// empty or its successor moves, so bubbles collapse and a stall on rsp
// holds everything in place. Synchronous active-high reset clears valids
// and presets the config registers; datapath registers stay as they are.
module charge_force_field_clamp #(
   parameter int FRAC_BITS   = ccf_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = ccf_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // first_x, first_y, first_z, second_x, second_y, second_z, zero fill
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // force_x, force_y, force_z, clamp_mask, zero fill
   output logic [ccf_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // near_zone
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  logic [ccf_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [ccf_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int CW      = COORD_WIDTH;
   localparam int QW      = ccf_pkg::QUO_W;
   localparam int DIFF_W  = CW + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int D2_W    = SQ_W + 2;
   localparam int RSQ_W   = 2 * ccf_pkg::RAD_W;
   localparam int LIM_W   = 2 * ccf_pkg::RAD_W + 2;
   localparam int DEN_W   = (D2_W > LIM_W) ? D2_W : LIM_W;
   localparam int PROD_W  = ccf_pkg::GAIN_W + DIFF_W;
   localparam int NUM_W   = PROD_W + FRAC_BITS;
   localparam int NHI_W   = NUM_W - QW;
   localparam int CMP_W   = (NHI_W > DEN_W) ? NHI_W : DEN_W;
   localparam int FRONT   = 6;
   localparam int NS      = FRONT + QW + 1;
   localparam int FW      = ccf_pkg::FORCE_W;

   // configuration registers
   logic signed [ccf_pkg::GAIN_W-1:0] gain_ff;
   logic [ccf_pkg::RAD_W-1:0]         radius_ff;
   logic [ccf_pkg::MAX_W-1:0]         max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= 32'sd65536;
         radius_ff <= 31'd65536;
         max_ff    <= 31'd196608;
      end else if (csr_we) begin
         unique case (csr_addr)
            ccf_pkg::REG_FIELD_GAIN:    gain_ff   <= csr_wdata;
            ccf_pkg::REG_SPHERE_RADIUS: radius_ff <= csr_wdata[ccf_pkg::RAD_W-1:0];
            ccf_pkg::REG_MAX_FORCE:     max_ff    <= csr_wdata[ccf_pkg::MAX_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valids and advance chain
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] adv;

   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_tready = adv[0];

   // S1: differences
   logic [2:0][DIFF_W-1:0] diff_ff, diff_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = {req_tdata[(3+i)*CW+CW-1], req_tdata[(3+i)*CW +: CW]}
                    - {req_tdata[i*CW+CW-1], req_tdata[i*CW +: CW]};
      end
   end
   always_ff @(posedge clock) if (adv[0]) diff_ff <= diff_in;

   // S2: magnitudes and result signs
   logic [2:0][DIFF_W-1:0]        mag_ff, mag_in;
   logic [2:0]                    neg2_ff, neg2_in;
   logic [ccf_pkg::GAIN_W-1:0]    gmag_ff, gmag_in;
   always_comb begin
      gmag_in = gain_ff[ccf_pkg::GAIN_W-1] ? -gain_ff : gain_ff;
      for (int i = 0; i < 3; i++) begin
         mag_in[i]  = diff_ff[i][DIFF_W-1] ? -diff_ff[i] : diff_ff[i];
         neg2_in[i] = diff_ff[i][DIFF_W-1] ^ gain_ff[ccf_pkg::GAIN_W-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         mag_ff  <= mag_in;
         neg2_ff <= neg2_in;
         gmag_ff <= gmag_in;
      end
   end

   // S3: squares, gain products, near-zone limit 4*r^2
   logic [2:0][SQ_W-1:0]   sq_ff;
   logic [2:0][PROD_W-1:0] prod3_ff;
   logic [LIM_W-1:0]       lim3_ff;
   logic [2:0]             neg3_ff;
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]    <= mag_ff[i] * mag_ff[i];
            prod3_ff[i] <= gmag_ff * mag_ff[i];
         end
         lim3_ff <= {RSQ_W'(radius_ff) * RSQ_W'(radius_ff), 2'b00};
         neg3_ff <= neg2_ff;
      end
   end

   // S4: squared distance
   logic [D2_W-1:0]        d2_ff;
   logic [2:0][PROD_W-1:0] prod4_ff;
   logic [LIM_W-1:0]       lim4_ff;
   logic [2:0]             neg4_ff;
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         d2_ff    <= D2_W'(sq_ff[0]) + D2_W'(sq_ff[1]) + D2_W'(sq_ff[2]);
         prod4_ff <= prod3_ff;
         lim4_ff  <= lim3_ff;
         neg4_ff  <= neg3_ff;
      end
   end

   // S5: branch select; denominator is 4*r^2 inside the near zone, else d2
   logic                   near_in;
   logic                   near5_ff;
   logic [DEN_W-1:0]       den5_ff;
   logic [2:0][PROD_W-1:0] prod5_ff;
   logic [2:0]             neg5_ff;
   assign near_in = DEN_W'(d2_ff) < DEN_W'(lim4_ff);
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         near5_ff <= near_in;
         den5_ff  <= near_in ? DEN_W'(lim4_ff) : DEN_W'(d2_ff);
         prod5_ff <= prod4_ff;
         neg5_ff  <= neg4_ff;
      end
   end

   // S6: quotient overflow test and divider seed; numerator is prod << FRAC_BITS
   logic [2:0][NUM_W-1:0]  num;
   logic [2:0][CMP_W-1:0]  nhi_ext;
   logic [2:0][DEN_W-1:0]  rem0_ff;
   logic [2:0][QW-1:0]     nlo_ff;
   logic [DEN_W-1:0]       den6_ff;
   ccf_pkg::ccf_side_type  side6_ff, side6_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i]     = {prod5_ff[i], {FRAC_BITS{1'b0}}};
         nhi_ext[i] = CMP_W'(num[i][NUM_W-1:QW]);
         side6_in.ovf[i] = nhi_ext[i] >= CMP_W'(den5_ff);
      end
      side6_in.neg  = neg5_ff;
      side6_in.dz   = den5_ff == '0;
      side6_in.near = near5_ff;
   end
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int i = 0; i < 3; i++) begin
            rem0_ff[i] <= nhi_ext[i][DEN_W-1:0];
            nlo_ff[i]  <= num[i][QW-1:0];
         end
         den6_ff  <= den5_ff;
         side6_ff <= side6_in;
      end
   end

   // divider: one quotient bit per stage
   logic [2:0][QW-1:0]    quo;
   ccf_pkg::ccf_side_type side_q;

   ccf_div_pipe #(
      .DEN_W (DEN_W),
      .QW    (QW)
   ) u_div (
      .clock    (clock),
      .en       (adv[FRONT +: QW]),
      .den      (den6_ff),
      .rem0     (rem0_ff),
      .nlo      (nlo_ff),
      .side     (side6_ff),
      .quo      (quo),
      .side_out (side_q)
   );

   // output: clamp, sign, mask
   logic [2:0][FW-1:0]           force_ff, force_in;
   logic [ccf_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic                         near_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [QW-1:0] m;
         m = '0;
         mask_in[i] = 1'b0;
         priority if (side_q.dz) begin
            m = '0;                 // zero radius at zero distance
         end else if (side_q.ovf[i] || quo[i] > QW'(max_ff)) begin
            m = QW'(max_ff);
            mask_in[i] = 1'b1;
         end else begin
            m = quo[i];
         end
         force_in[i] = side_q.neg[i] ? FW'(-m) : FW'(m);
      end
   end
   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         force_ff <= force_in;
         mask_ff  <= mask_in;
         near_ff  <= side_q.near;
      end
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tuser  = near_ff;
   assign rsp_tdata  = ccf_pkg::RSP_DATA_W'({mask_ff, force_ff[2], force_ff[1], force_ff[0]});

   // checks
   a_clamp_x: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mask_ff[0] |-> force_ff[0] == FW'(max_ff) || force_ff[0] == -FW'(max_ff))
      else $error("x clamp flag without max magnitude");

   a_clamp_z: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mask_ff[2] |-> force_ff[2] == FW'(max_ff) || force_ff[2] == -FW'(max_ff))
      else $error("z clamp flag without max magnitude");

   a_near_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && near_ff |-> radius_ff != '0)
      else $error("near zone with zero radius");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted beat lost at entry");

endmodule
